>>> rtl/assert_macros.svh
// Assertion macros shared by the blend RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mlrb_pkg.sv
// Shared constants and types of the masked layer replace blend.
package mlrb_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int NUM_LANES        = 3;
    localparam int NUM_IN_FIELDS    = 9;
    localparam int NUM_OUT_FIELDS   = 4;
    localparam int AFFECT_BITS      = 4;
    localparam int ALPHA_CH         = 3;
    localparam int FRONT_STAGES     = 5;

    // Configuration register indexes
    typedef enum logic {
        REG_OPACITY,
        REG_AFFECT
    } t_reg_index;

    // Per-request control that travels beside the color lanes
    typedef struct packed {
        logic valid;
        logic force_use;
    } t_blend_ctl;

endpackage

>>> rtl/mlrb_front.sv
// Front end: effective mask, blended alpha and divider operands for the color lanes.
`include "assert_macros.svh"

module mlrb_front
    import mlrb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [CHANNEL_BITS-1:0]   i_top [0:3],
    input  logic [CHANNEL_BITS-1:0]   i_bottom [0:3],
    input  logic [CHANNEL_BITS-1:0]   i_mask_level,
    input  logic [CHANNEL_BITS-1:0]   i_opacity,
    output t_blend_ctl                o_ctl,
    output logic [CHANNEL_BITS-1:0]   o_top [0:NUM_LANES-1],
    output logic [CHANNEL_BITS-1:0]   o_bottom [0:NUM_LANES-1],
    output logic [CHANNEL_BITS-1:0]   o_bottom_alpha,
    output logic [CHANNEL_BITS-1:0]   o_alpha,
    output logic [2*CHANNEL_BITS-1:0] o_weight,
    output logic [2*CHANNEL_BITS-1:0] o_denom
);

    localparam int W  = CHANNEL_BITS;
    localparam int W1 = CHANNEL_BITS + 1;
    localparam int W2 = 2 * CHANNEL_BITS;
    localparam logic [W-1:0]  FULL    = {W{1'b1}};
    localparam logic [W2-1:0] HALF    = {{W1{1'b0}}, {(W - 1){1'b1}}};
    localparam logic [W2-1:0] FULL_SQ = W2'(FULL) * W2'(FULL);

    // floor(y / FULL) for y below FULL * 2^W: fold the high half back onto the low half
    function automatic logic [W-1:0] div_full(input logic [W2-1:0] y);
        logic [W-1:0] q0;
        logic [W:0]   rem;
        logic [W:0]   q;
        q0  = y[W2-1:W];
        rem = {1'b0, y[W-1:0]} + {1'b0, q0};
        q   = {1'b0, q0} + W1'(rem >= {1'b0, FULL}) + W1'(rem >= {FULL, 1'b0});
        return q[W-1:0];
    endfunction

    logic [FRONT_STAGES-1:0] r_valid;
    logic [W-1:0]  r_top_d [0:FRONT_STAGES-1][0:3];
    logic [W-1:0]  r_bot_d [0:FRONT_STAGES-1][0:3];
    logic [W2-1:0] r_p1;
    logic [W-1:0]  r_m2, r_mc2;
    logic [W2-1:0] r_wb3, r_wt3;
    logic [W-1:0]  r_m3;
    logic [W2-1:0] r_anum4, r_wt4;
    logic [W-1:0]  r_m4;
    logic          r_bz4, r_tz4;
    logic [W2-1:0] r_weight5, r_denom5;
    logic [W-1:0]  r_alpha5;
    logic          r_force5;
    logic [W2-1:0] n_weight, n_denom;
    logic          n_force;

    // Track which stages hold a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[FRONT_STAGES-2:0], i_valid};
        end
    end

    // Pick divider operands, including the zero-alpha limit cases
    always_comb begin
        n_force = 1'b0;
        if (r_anum4 != '0) begin
            n_weight = r_wt4;
            n_denom  = r_anum4;
        end else if (r_bz4 && r_tz4) begin
            // both alphas clear: plain lerp by the mask
            n_weight = W2'(r_m4);
            n_denom  = W2'(FULL);
        end else if (r_bz4) begin
            // bottom alpha and mask both zero: keep bottom in every channel
            n_weight = '0;
            n_denom  = W2'(FULL);
            n_force  = 1'b1;
        end else begin
            // full mask over a clear top: take top
            n_weight = W2'(FULL);
            n_denom  = W2'(FULL);
        end
    end

    // Advance the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top_d[0] <= i_top;
            r_bot_d[0] <= i_bottom;
            for (int s = 1; s < FRONT_STAGES; s++) begin
                r_top_d[s] <= r_top_d[s-1];
                r_bot_d[s] <= r_bot_d[s-1];
            end
            r_p1      <= W2'(i_mask_level) * W2'(i_opacity);
            r_m2      <= div_full(r_p1 + HALF);
            r_mc2     <= FULL - div_full(r_p1 + HALF);
            r_wb3     <= W2'(r_bot_d[1][ALPHA_CH]) * W2'(r_mc2);
            r_wt3     <= W2'(r_top_d[1][ALPHA_CH]) * W2'(r_m2);
            r_m3      <= r_m2;
            r_anum4   <= r_wb3 + r_wt3;
            r_wt4     <= r_wt3;
            r_m4      <= r_m3;
            r_bz4     <= (r_bot_d[2][ALPHA_CH] == '0);
            r_tz4     <= (r_top_d[2][ALPHA_CH] == '0);
            r_alpha5  <= div_full(r_anum4 + HALF);
            r_weight5 <= n_weight;
            r_denom5  <= n_denom;
            r_force5  <= n_force;
        end
    end

    assign o_ctl.valid     = r_valid[FRONT_STAGES-1];
    assign o_ctl.force_use = r_force5;
    assign o_bottom_alpha  = r_bot_d[FRONT_STAGES-1][ALPHA_CH];
    assign o_alpha         = r_alpha5;
    assign o_weight        = r_weight5;
    assign o_denom         = r_denom5;

    always_comb begin
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            o_top[ch]    = r_top_d[FRONT_STAGES-1][ch];
            o_bottom[ch] = r_bot_d[FRONT_STAGES-1][ch];
        end
    end

    `ASSERT_IMPL(a_alpha_num_bound, i_clk, i_rst_n, r_valid[3], r_anum4 <= FULL_SQ, "alpha numerator above full scale")
    `ASSERT_IMPL(a_weight_le_denom, i_clk, i_rst_n, o_ctl.valid, o_weight <= o_denom, "lane weight exceeds denominator")
    `ASSERT_IMPL(a_denom_nonzero, i_clk, i_rst_n, o_ctl.valid, o_denom != '0, "lane denominator is zero")

endmodule

>>> rtl/mlrb_lane.sv
// Color lane: rounded bottom-to-top mix through a one-bit-per-stage divider.
module mlrb_lane
    import mlrb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [CHANNEL_BITS-1:0]   i_bottom,
    input  logic [CHANNEL_BITS-1:0]   i_top,
    input  logic [2*CHANNEL_BITS-1:0] i_weight,
    input  logic [2*CHANNEL_BITS-1:0] i_denom,
    output logic [CHANNEL_BITS-1:0]   o_value,
    output logic [CHANNEL_BITS-1:0]   o_bottom
);

    localparam int W  = CHANNEL_BITS;
    localparam int W2 = 2 * CHANNEL_BITS;
    localparam int RW = 2 * CHANNEL_BITS + 2;

    logic [W-1:0]  r_c   [0:W-1];
    logic [W2-1:0] r_w   [0:W-1];
    logic          r_dir [0:W];
    logic [W-1:0]  r_b   [0:W];
    logic [W2-1:0] r_d   [0:W];
    logic [W2-1:0] r_r   [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic [W-1:0]  r_value, r_bout;
    logic [W2-1:0] n_r   [1:W];
    logic [W-1:0]  n_q   [1:W];
    logic [W-1:0]  n_qr;
    logic          n_round;

    // One quotient digit per stage, MSB of the magnitude first
    for (genvar k = 1; k <= W; k++) begin : g_step
        always_comb begin
            logic [RW-1:0] sum;
            logic [RW-1:0] d1;
            logic [RW-1:0] d2;
            logic [RW-1:0] rem;
            logic [1:0]    dig;
            sum = {1'b0, r_r[k-1], 1'b0} + (r_c[k-1][W-k] ? RW'(r_w[k-1]) : '0);
            d1  = RW'(r_d[k-1]);
            d2  = {1'b0, r_d[k-1], 1'b0};
            if (sum >= d2) begin
                rem = sum - d2;
                dig = 2'd2;
            end else if (sum >= d1) begin
                rem = sum - d1;
                dig = 2'd1;
            end else begin
                rem = sum;
                dig = 2'd0;
            end
            n_r[k] = rem[W2-1:0];
            n_q[k] = {r_q[k-1][W-2:0], 1'b0} + W'(dig);
        end
    end

    // Round half away from bottom
    assign n_round = ({r_r[W], 1'b0} >= {1'b0, r_d[W]});
    assign n_qr    = r_q[W] + W'(n_round);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // load magnitude and direction of top minus bottom
            r_dir[0] <= (i_top < i_bottom);
            r_c[0]   <= (i_top < i_bottom) ? (i_bottom - i_top) : (i_top - i_bottom);
            r_b[0]   <= i_bottom;
            r_w[0]   <= i_weight;
            r_d[0]   <= i_denom;
            r_r[0]   <= '0;
            r_q[0]   <= '0;
            for (int k = 1; k <= W; k++) begin
                r_dir[k] <= r_dir[k-1];
                r_b[k]   <= r_b[k-1];
                r_d[k]   <= r_d[k-1];
                r_r[k]   <= n_r[k];
                r_q[k]   <= n_q[k];
            end
            for (int k = 1; k < W; k++) begin
                r_c[k] <= r_c[k-1];
                r_w[k] <= r_w[k-1];
            end
            r_value <= r_dir[W] ? (r_b[W] - n_qr) : (r_b[W] + n_qr);
            r_bout  <= r_b[W];
        end
    end

    assign o_value  = r_value;
    assign o_bottom = r_bout;

endmodule

>>> rtl/mlrb_merge.sv
// Merge stage: per-channel affect selection and two-entry output skid buffer.
`include "assert_macros.svh"

module mlrb_merge
    import mlrb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_force_use,
    input  logic [AFFECT_BITS-1:0]  i_affect,
    input  logic [CHANNEL_BITS-1:0] i_blend [0:NUM_LANES-1],
    input  logic [CHANNEL_BITS-1:0] i_bottom [0:NUM_LANES-1],
    input  logic [CHANNEL_BITS-1:0] i_alpha,
    input  logic [CHANNEL_BITS-1:0] i_bottom_alpha,
    output logic                    o_full,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha from bit 0 up, zero padded
    output logic [((NUM_OUT_FIELDS*CHANNEL_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int W        = CHANNEL_BITS;
    localparam int WORD     = NUM_OUT_FIELDS * CHANNEL_BITS;
    localparam int OUT_BITS = ((NUM_OUT_FIELDS * CHANNEL_BITS + 7) / 8) * 8;
    localparam logic [1:0] SKID_DEPTH = 2'd2;

    logic [WORD-1:0] r_mem [0:1];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;
    logic [WORD-1:0] n_word;
    logic            n_pop;

    // Drop the blend on channels whose affect bit is clear, unless the force flag keeps a color lane
    always_comb begin
        n_word = '0;
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            n_word[ch*W +: W] = (i_affect[ch] || i_force_use) ? i_blend[ch] : i_bottom[ch];
        end
        n_word[ALPHA_CH*W +: W] = i_affect[ALPHA_CH] ? i_alpha : i_bottom_alpha;
    end

    assign n_pop = o_m_axis_tvalid && i_m_axis_tready;

    // Hold finished requests until the sink takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(n_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= n_word;
        end
    end

    assign o_full          = (r_count == SKID_DEPTH);
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = OUT_BITS'(r_mem[r_rd_ptr]);

    `ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push, r_count != SKID_DEPTH, "push into full skid buffer")
    `ASSERT_NEXT(a_push_keeps_data, i_clk, i_rst_n, i_push && !n_pop, r_count != '0, "pushed request lost")

endmodule

>>> rtl/masked_layer_replace_blend_top.sv
// Path: an accepted request passes five front stages for mask and alpha, then a lane divider
// that retires one quotient bit per stage, then the skid buffer, before its result shows on
// the master side; the skid buffer sets ready.
// Throughput: one pixel per cycle while the skid buffer has room; every stage is pipelined.
// Reset: synchronous, active low; clears all valid bits and the skid buffer, and sets
// opacity to full scale and all four affect bits.
module masked_layer_replace_blend_top
    import mlrb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // top_red, top_green, top_blue, top_alpha, bottom_red, bottom_green, bottom_blue,
    // bottom_alpha, mask_level from bit 0 up, zero padded
    input  logic [((NUM_IN_FIELDS*CHANNEL_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha from bit 0 up, zero padded
    output logic [((NUM_OUT_FIELDS*CHANNEL_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [CHANNEL_BITS-1:0] i_cfg_data
);

    localparam int W        = CHANNEL_BITS;
    localparam int W2       = 2 * CHANNEL_BITS;
    localparam int LANE_LAT = CHANNEL_BITS + 2;

    logic [W-1:0]           r_opacity;
    logic [AFFECT_BITS-1:0] r_affect;
    logic                   w_full, w_adv;
    logic [W-1:0]           w_in_top [0:3];
    logic [W-1:0]           w_in_bot [0:3];
    t_blend_ctl             w_ctl;
    logic [W-1:0]           w_f_top [0:NUM_LANES-1];
    logic [W-1:0]           w_f_bot [0:NUM_LANES-1];
    logic [W-1:0]           w_f_balpha, w_f_alpha;
    logic [W2-1:0]          w_weight, w_denom;
    logic [W-1:0]           w_blend [0:NUM_LANES-1];
    logic [W-1:0]           w_lane_bot [0:NUM_LANES-1];
    logic [LANE_LAT-1:0]    r_sb_valid, r_sb_force;
    logic [W-1:0]           r_sb_alpha  [0:LANE_LAT-1];
    logic [W-1:0]           r_sb_balpha [0:LANE_LAT-1];

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= {W{1'b1}};
            r_affect  <= {AFFECT_BITS{1'b1}};
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_OPACITY: r_opacity <= i_cfg_data;
                REG_AFFECT:  r_affect  <= i_cfg_data[AFFECT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Advance the whole pipeline while the skid buffer has room
    assign w_adv           = !w_full;
    assign o_s_axis_tready = w_adv;

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            w_in_top[ch] = i_s_axis_tdata[ch*W +: W];
            w_in_bot[ch] = i_s_axis_tdata[(ch + 4)*W +: W];
        end
    end

    mlrb_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_valid        (i_s_axis_tvalid),
        .i_top          (w_in_top),
        .i_bottom       (w_in_bot),
        .i_mask_level   (i_s_axis_tdata[8*W +: W]),
        .i_opacity      (r_opacity),
        .o_ctl          (w_ctl),
        .o_top          (w_f_top),
        .o_bottom       (w_f_bot),
        .o_bottom_alpha (w_f_balpha),
        .o_alpha        (w_f_alpha),
        .o_weight       (w_weight),
        .o_denom        (w_denom)
    );

    for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
        mlrb_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_bottom (w_f_bot[ch]),
            .i_top    (w_f_top[ch]),
            .i_weight (w_weight),
            .i_denom  (w_denom),
            .o_value  (w_blend[ch]),
            .o_bottom (w_lane_bot[ch])
        );
    end

    // Carry valid, force flag and alphas alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= '0;
        end else if (w_adv) begin
            r_sb_valid <= {r_sb_valid[LANE_LAT-2:0], w_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb_force     <= {r_sb_force[LANE_LAT-2:0], w_ctl.force_use};
            r_sb_alpha[0]  <= w_f_alpha;
            r_sb_balpha[0] <= w_f_balpha;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_sb_alpha[s]  <= r_sb_alpha[s-1];
                r_sb_balpha[s] <= r_sb_balpha[s-1];
            end
        end
    end

    mlrb_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_adv && r_sb_valid[LANE_LAT-1]),
        .i_force_use     (r_sb_force[LANE_LAT-1]),
        .i_affect        (r_affect),
        .i_blend         (w_blend),
        .i_bottom        (w_lane_bot),
        .i_alpha         (r_sb_alpha[LANE_LAT-1]),
        .i_bottom_alpha  (r_sb_balpha[LANE_LAT-1]),
        .o_full          (w_full),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> dv/masked_layer_replace_blend_top_tb.sv
// Self-checking stream testbench for the masked layer replace blend top level.
`timescale 1ns / 100ps

module masked_layer_replace_blend_top_tb;
    import mlrb_pkg::*;

    localparam int          CB       = CHANNEL_BITS_DEF;
    localparam int          CH_MAX   = (1 << CB) - 1;
    localparam logic [63:0] FULL     = (64'd1 << CB) - 64'd1;
    localparam int          IN_W     = ((NUM_IN_FIELDS * CB + 7) / 8) * 8;
    localparam int          OUT_W    = ((NUM_OUT_FIELDS * CB + 7) / 8) * 8;
    localparam int          LATENCY  = CB + 7;
    localparam int          HOLD_LEN = 300;
    localparam int          RND_PH   = 8;
    localparam int          RND_ITEMS = 180;

    // One pixel request, first field in the lowest bits
    typedef struct packed {
        logic [CB-1:0] mask_level;
        logic [CB-1:0] bottom_alpha;
        logic [CB-1:0] bottom_blue;
        logic [CB-1:0] bottom_green;
        logic [CB-1:0] bottom_red;
        logic [CB-1:0] top_alpha;
        logic [CB-1:0] top_blue;
        logic [CB-1:0] top_green;
        logic [CB-1:0] top_red;
    } t_pixel;

    // One blended result, first field in the lowest bits
    typedef struct packed {
        logic [CB-1:0] out_alpha;
        logic [CB-1:0] out_blue;
        logic [CB-1:0] out_green;
        logic [CB-1:0] out_red;
    } t_rgba;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             i_cfg_we = 1'b0;
    logic [0:0]       i_cfg_index = '0;
    logic [CB-1:0]    i_cfg_data = '0;

    // Pending pixels and blended results still owed by the block
    t_pixel        pixel_q[$];
    t_rgba         blend_q[$];

    // Shadow copy of the configuration registers
    logic [CB-1:0] cur_opacity = CB'(CH_MAX);
    logic [3:0]    cur_affect  = 4'hF;

    // Source and sink pacing
    int            src_gap_max = 0;
    int            sink_gap_max = 0;
    int            src_gap = 0;
    int            sink_gap = 0;
    int            hold_left = 0;
    bit            src_busy = 1'b0;
    bit            src_taken = 1'b0;
    bit            sink_taken = 1'b0;
    bit            sink_hold_req = 1'b0;
    logic          rdy;
    t_pixel        cur_px = '0;

    // Run statistics
    int            n_in = 0;
    int            n_out = 0;
    int            n_cfg = 0;
    int            n_err = 0;
    t_rgba         want;
    t_rgba         got;

    masked_layer_replace_blend_top #(
        .CHANNEL_BITS(CB)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // round(c * w / d), half rounded away from zero
    function automatic logic [63:0] round_frac(logic [63:0] c, logic [63:0] w, logic [63:0] d);
        return (2 * c * w + d) / (2 * d);
    endfunction

    // Move from bottom toward top by the fraction w / d
    function automatic logic [CB-1:0] lane_mix(logic [63:0] b, logic [63:0] t, logic [63:0] w,
                                               logic [63:0] d);
        if (t >= b)
            return CB'(b + round_frac(t - b, w, d));
        return CB'(b - round_frac(b - t, w, d));
    endfunction

    // Expected blend of one pixel under the given register values
    function automatic t_rgba blend_pixel(t_pixel px, logic [CB-1:0] opac, logic [3:0] aff);
        logic [63:0]   t [4];
        logic [63:0]   b [4];
        logic [63:0]   m;
        logic [63:0]   wt;
        logic [63:0]   anum;
        logic [63:0]   aout;
        logic [CB-1:0] lane [3];
        logic [CB-1:0] v;
        logic          use_ch;
        t_rgba         r;
        t[0] = 64'(px.top_red);
        t[1] = 64'(px.top_green);
        t[2] = 64'(px.top_blue);
        t[3] = 64'(px.top_alpha);
        b[0] = 64'(px.bottom_red);
        b[1] = 64'(px.bottom_green);
        b[2] = 64'(px.bottom_blue);
        b[3] = 64'(px.bottom_alpha);
        m    = (2 * 64'(px.mask_level) * 64'(opac) + FULL) / (2 * FULL);
        wt   = t[3] * m;
        anum = b[3] * (FULL - m) + wt;
        aout = (2 * anum + FULL) / (2 * FULL);
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            use_ch = aff[ch];
            if (anum != 0) begin
                v = lane_mix(b[ch], t[ch], wt, anum);
            end else if (b[3] == 0 && t[3] == 0) begin
                // both layers transparent: plain lerp by the mask
                v = lane_mix(b[ch], t[ch], m, FULL);
            end else if (b[3] == 0 && m == 0) begin
                // empty bottom and no coverage: bottom color on every lane
                v = b[ch][CB-1:0];
                use_ch = 1'b1;
            end else begin
                // full coverage by a transparent top: top color
                v = t[ch][CB-1:0];
            end
            lane[ch] = use_ch ? v : b[ch][CB-1:0];
        end
        r.out_red   = lane[0];
        r.out_green = lane[1];
        r.out_blue  = lane[2];
        r.out_alpha = aff[ALPHA_CH] ? aout[CB-1:0] : b[3][CB-1:0];
        return r;
    endfunction

    function automatic t_pixel mk_px(int tr, int tg, int tb, int ta, int br, int bg, int bb,
                                     int ba, int mk);
        t_pixel p;
        p.top_red      = CB'(tr);
        p.top_green    = CB'(tg);
        p.top_blue     = CB'(tb);
        p.top_alpha    = CB'(ta);
        p.bottom_red   = CB'(br);
        p.bottom_green = CB'(bg);
        p.bottom_blue  = CB'(bb);
        p.bottom_alpha = CB'(ba);
        p.mask_level   = CB'(mk);
        return p;
    endfunction

    // Level biased toward the ends of the range
    function automatic logic [CB-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CB'(CH_MAX);
            2: return CB'(1);
            3: return CB'(CH_MAX - 1);
            default: return CB'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    function automatic t_pixel rand_px();
        t_pixel p;
        p.top_red      = CB'($urandom_range(0, CH_MAX));
        p.top_green    = CB'($urandom_range(0, CH_MAX));
        p.top_blue     = ($urandom_range(0, 3) == 0) ? pick_level() : CB'($urandom_range(0, CH_MAX));
        p.top_alpha    = pick_level();
        p.bottom_red   = CB'($urandom_range(0, CH_MAX));
        p.bottom_green = CB'($urandom_range(0, CH_MAX));
        p.bottom_blue  = ($urandom_range(0, 3) == 0) ? pick_level() : CB'($urandom_range(0, CH_MAX));
        p.bottom_alpha = pick_level();
        p.mask_level   = pick_level();
        return p;
    endfunction

    task automatic write_reg(t_reg_index idx, logic [CB-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == REG_OPACITY)
            cur_opacity = val;
        else
            cur_affect = val[3:0];
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every pending pixel is in and every blend has come back
    task automatic wait_idle();
        while (pixel_q.size() != 0 || src_busy || blend_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [CB-1:0] exp_v, logic [CB-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    // Drive requests: advance on acceptance, insert the drawn gap before the next one
    always @(negedge i_clk) begin
        if (src_taken) begin
            src_taken = 1'b0;
            src_busy  = 1'b0;
            src_gap   = $urandom_range(0, src_gap_max);
        end
        if (!src_busy) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pixel_q.size() > 0) begin
                cur_px   = pixel_q.pop_front();
                src_busy = 1'b1;
            end
        end
        i_s_axis_tvalid <= src_busy;
        i_s_axis_tdata  <= cur_px;
    end

    // Pace the result side: per-result gaps plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (sink_taken) begin
            sink_taken = 1'b0;
            sink_gap   = $urandom_range(0, sink_gap_max);
        end
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            hold_left     = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_m_axis_tready <= rdy;
    end

    // Predict on accepted requests, check accepted results against the oldest blend
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                blend_q.push_back(blend_pixel(t_pixel'(i_s_axis_tdata), cur_opacity, cur_affect));
                src_taken = 1'b1;
                n_in++;
            end
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                sink_taken = 1'b1;
                n_out++;
                if (blend_q.size() == 0) begin
                    $error("result with no pending request: %h", o_m_axis_tdata);
                    n_err++;
                end else begin
                    want = blend_q.pop_front();
                    got  = t_rgba'(o_m_axis_tdata);
                    check_field("out_red", want.out_red, got.out_red);
                    check_field("out_green", want.out_green, got.out_green);
                    check_field("out_blue", want.out_blue, got.out_blue);
                    check_field("out_alpha", want.out_alpha, got.out_alpha);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners, transparent layers, rounding halves
        src_gap_max  = 12;
        sink_gap_max = 12;
        pixel_q.push_back(mk_px(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                                'hFFFF, 'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 0, 'hFFFF, 0, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h1234, 'hFFFF, 0, 0, 0));
        pixel_q.push_back(mk_px('hFFFF, 0, 'hAAAA, 0, 0, 'hFFFF, 'h5555, 0, 'h8000));
        pixel_q.push_back(mk_px(1, 0, 1, 'hFFFF, 0, 1, 0, 'hFFFF, 'h8000));
        pixel_q.push_back(mk_px('hAAAA, 'h5555, 'hAAAA, 'h5555, 'h5555, 'hAAAA, 'h5555,
                                'hAAAA, 'hAAAA));
        pixel_q.push_back(mk_px('h5555, 'hAAAA, 'h5555, 'hAAAA, 'hAAAA, 'h5555, 'hAAAA,
                                'h5555, 'h5555));
        pixel_q.push_back(mk_px('hFFFF, 0, 'h8000, 1, 0, 'hFFFF, 'h7FFF, 'hFFFE, 1));
        pixel_q.push_back(mk_px(0, 'hFFFF, 1, 'hFFFE, 'hFFFF, 0, 'hFFFE, 1, 'hFFFE));
        pixel_q.push_back(mk_px('h100, 'h200, 'h300, 1, 'h400, 'h500, 'h600, 1, 'h8000));
        wait_idle();

        // No opacity, no lanes affected; upper data bits of the affect write ignored
        write_reg(REG_OPACITY, 16'h0000);
        write_reg(REG_AFFECT, 16'hFFF0);
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h1234, 'h5678, 'h9ABC, 0,
                                'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 0, 'hFFFF, 'hFFFF, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF));
        pixel_q.push_back(mk_px(0, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 0, 'h8000));
        wait_idle();

        // Smallest nonzero opacity, red and blue affected
        write_reg(REG_OPACITY, 16'h0001);
        write_reg(REG_AFFECT, 16'h0005);
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 0, 'hFFFF, 0, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF));
        pixel_q.push_back(mk_px(0, 0, 0, 0, 1, 2, 3, 0, 'hFFFF));
        wait_idle();

        // Full opacity, green and alpha affected
        write_reg(REG_OPACITY, 16'hFFFF);
        write_reg(REG_AFFECT, 16'h5A5A);
        pixel_q.push_back(mk_px('hFFFF, 0, 'hFFFF, 0, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF));
        pixel_q.push_back(mk_px('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 9, 9, 9, 0, 0));
        pixel_q.push_back(mk_px(0, 'hFFFF, 0, 'hFFFF, 'hFFFF, 0, 'hFFFF, 0, 'h8000));
        pixel_q.push_back(mk_px('hAAAA, 'h5555, 'hAAAA, 'h5555, 'h5555, 'hAAAA, 'h5555,
                                'hAAAA, 'h5555));
        wait_idle();

        // Random phases, each under its own settings and pacing
        for (int ph = 0; ph < RND_PH; ph++) begin
            if (ph == 0) begin
                write_reg(REG_OPACITY, CB'(CH_MAX));
                write_reg(REG_AFFECT, 16'h000F);
            end else if (ph == 1) begin
                write_reg(REG_OPACITY, '0);
                write_reg(REG_AFFECT, '0);
            end else begin
                write_reg(REG_OPACITY, pick_level());
                write_reg(REG_AFFECT, CB'($urandom_range(0, CH_MAX)));
            end
            case (ph % 4)
                0: begin src_gap_max = 0;  sink_gap_max = 0;  end
                1: begin src_gap_max = 12; sink_gap_max = 12; end
                2: begin src_gap_max = 0;  sink_gap_max = 12; end
                default: begin src_gap_max = 12; sink_gap_max = 0; end
            endcase
            for (int k = 0; k < RND_ITEMS; k++)
                pixel_q.push_back(rand_px());
            // Back up the pipeline while requests keep coming at full rate
            if (ph == 2)
                sink_hold_req = 1'b1;
            wait_idle();
        end

        $display("Blended %0d pixels, checked %0d results across %0d register writes,",
                 n_in, n_out, n_cfg);
        $display("covering transparent-layer limits, lane masking and input back-pressure.");
        if (n_err == 0 && blend_q.size() == 0) begin
            $display("masked_layer_replace_blend_top: match");
        end else begin
            $display("masked_layer_replace_blend_top: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("masked_layer_replace_blend_top: mismatch");
        $finish;
    end

endmodule
